[rtl/core/acd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive CUSUM change detector: shared definitions
// Widths, register codes, reset values, state encoding, control structs and
// the 16-bit saturation helper used by the detector core.
// ----------------------------------------------------------------------------
package acd_pkg;

  // Sample width and the stream word that carries it.
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;

  // Result word: alarm, instant flag, CUSUM and D packed from bit 0 up.
  localparam int unsigned RES_BITS  = 1 + 1 + 16 + 16;
  localparam int unsigned M_TDATA_W = ((RES_BITS + 7) / 8) * 8;

  // Bit-serial multiplier operand width and step counter width.
  localparam int unsigned MUL_W     = 16;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_W);
  localparam int unsigned HALF_W    = 2 * MUL_W - 1;

  // Configuration channel.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  // Register reset values.
  localparam logic [11:0] RST_REF_MEAN  = 12'd0;
  localparam logic [7:0]  RST_DELTA     = 8'd1;
  localparam logic [7:0]  RST_GAIN      = 8'd1;
  localparam logic [14:0] RST_THRESHOLD = 15'd20;
  localparam logic [12:0] RST_CEILING   = 13'd4096;
  localparam logic [14:0] RST_DEADBAND  = 15'd10;
  localparam logic [14:0] RST_D_BOUND   = 15'd8;

  // Saturation limits for 16-bit signed results.
  localparam logic signed [15:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAT_MIN = 16'sh8000;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REFERENCE_MEAN   = 3'd0,
    REG_STEP_DELTA       = 3'd1,
    REG_ADAPT_GAIN       = 3'd2,
    REG_ALARM_THRESHOLD  = 3'd3,
    REG_ESTIMATE_CEILING = 3'd4,
    REG_Z_DEADBAND       = 3'd5,
    REG_D_BOUND          = 3'd6
  } acd_reg_e;

  // Sequencer states: one load and one wait state per multiplier pass.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_A,
    ST_WAIT_A,
    ST_LOAD_B,
    ST_WAIT_B,
    ST_LOAD_G,
    ST_WAIT_G,
    ST_LOAD_M,
    ST_WAIT_M,
    ST_LOAD_E,
    ST_WAIT_E,
    ST_UPDATE,
    ST_OUT
  } acd_state_e;

  // Configuration register contents, plus a pulse to reload the estimate.
  typedef struct packed {
    logic [11:0] ref_mean;
    logic [7:0]  step_delta;
    logic [7:0]  adapt_gain;
    logic [14:0] alarm_threshold;
    logic [12:0] estimate_ceiling;
    logic [14:0] z_deadband;
    logic [14:0] d_bound;
    logic        reload;
  } acd_cfg_t;

  // Multiplier request and response.
  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] op_a;
    logic [MUL_W-1:0] op_b;
  } acd_mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [2*MUL_W-1:0] product;
  } acd_mul_rsp_t;

  // Clamp a 32-bit signed value to the 16-bit signed range.
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = SAT_MAX;
    end else if (v < -32'sd32768) begin
      r = SAT_MIN;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/acd_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive CUSUM change detector: configuration registers
// Holds the seven tuning registers and flags a reload of the lower estimate
// whenever the reference mean or the step delta is written.
// ----------------------------------------------------------------------------
module acd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [acd_pkg::CFG_IDX_W-1:0]  wr_addr_i,
  input  logic [acd_pkg::CFG_DATA_W-1:0] wr_data_i,
  output acd_pkg::acd_cfg_t              cfg_o
);

  acd_pkg::acd_cfg_t cfg_d, cfg_q;

  // Decode a write; each value is cut to its register width.
  always_comb begin
    cfg_d        = cfg_q;
    cfg_d.reload = 1'b0;
    if (wr_en_i) begin
      unique case (acd_pkg::acd_reg_e'(wr_addr_i))
        acd_pkg::REG_REFERENCE_MEAN: begin
          cfg_d.ref_mean = wr_data_i[11:0];
          cfg_d.reload   = 1'b1;
        end
        acd_pkg::REG_STEP_DELTA: begin
          cfg_d.step_delta = wr_data_i[7:0];
          cfg_d.reload     = 1'b1;
        end
        acd_pkg::REG_ADAPT_GAIN:       cfg_d.adapt_gain       = wr_data_i[7:0];
        acd_pkg::REG_ALARM_THRESHOLD:  cfg_d.alarm_threshold  = wr_data_i[14:0];
        acd_pkg::REG_ESTIMATE_CEILING: cfg_d.estimate_ceiling = wr_data_i[12:0];
        acd_pkg::REG_Z_DEADBAND:       cfg_d.z_deadband       = wr_data_i[14:0];
        acd_pkg::REG_D_BOUND:          cfg_d.d_bound          = wr_data_i[14:0];
        default: begin
          // Unmapped index: the write is dropped.
        end
      endcase
    end
  end

  // Register file with its documented reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_mean         <= acd_pkg::RST_REF_MEAN;
      cfg_q.step_delta       <= acd_pkg::RST_DELTA;
      cfg_q.adapt_gain       <= acd_pkg::RST_GAIN;
      cfg_q.alarm_threshold  <= acd_pkg::RST_THRESHOLD;
      cfg_q.estimate_ceiling <= acd_pkg::RST_CEILING;
      cfg_q.z_deadband       <= acd_pkg::RST_DEADBAND;
      cfg_q.d_bound          <= acd_pkg::RST_D_BOUND;
      cfg_q.reload           <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/acd_serial_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive CUSUM change detector: bit-serial multiplier
// Unsigned shift-add multiplier on a single narrow adder that retires one
// multiplier bit per cycle.
// ----------------------------------------------------------------------------
module acd_serial_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  acd_pkg::acd_mul_req_t req_i,
  output acd_pkg::acd_mul_rsp_t rsp_o
);

  logic [acd_pkg::MUL_W-1:0]     mcand_d, mcand_q;
  logic [acd_pkg::MUL_W-1:0]     hi_d, hi_q;
  logic [acd_pkg::MUL_W-1:0]     lo_d, lo_q;
  logic [acd_pkg::MUL_CNT_W-1:0] cnt_d, cnt_q;
  logic                          busy_d, busy_q;
  logic                          done_d, done_q;
  logic [acd_pkg::MUL_W:0]       step_sum;

  // Add the multiplicand into the upper half when the current bit is set.
  assign step_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

  // Load on start, then shift the product right one bit per cycle.
  always_comb begin
    mcand_d = mcand_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      mcand_d = req_i.op_a;
      hi_d    = '0;
      lo_d    = req_i.op_b;
      cnt_d   = acd_pkg::MUL_CNT_W'(acd_pkg::MUL_W - 1);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      hi_d = step_sum[acd_pkg::MUL_W:1];
      lo_d = {step_sum[0], lo_q[acd_pkg::MUL_W-1:1]};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Operand and product shift registers.
  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.done    = done_q;
  assign rsp_o.product = {hi_q, lo_q};

endmodule

[rtl/core/adaptive_cusum_change_detector_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive CUSUM change detector core
// Tracks an adaptive estimate of the changed sample mean, accumulates a
// CUSUM of the log-likelihood ratio and raises a sticky change alarm.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata[11:0] sample
// m_axis    out        m_axis_tvalid/m_axis_tready  alarm, instant, cusum, D
// cfg       in         cfg_valid_i/cfg_ready_o      cfg_addr_i, cfg_data_i
//
// Each sample runs five 16-step passes through the shared bit-serial
// multiplier, then a CUSUM update state and a state that loads the result
// register; that last state waits while the output register is still full.
// A finished result waits in the output register while the next sample is
// taken. Configuration writes are always ready and are registered.
// Reset is asynchronous, active low, and restores every register default.
//
module adaptive_cusum_change_detector_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Sample stream. tdata: [11:0] sample, rest zero.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [acd_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  // Result stream. tdata: [0] change_alarm, [1] instant_change,
  // [17:2] cusum_value, [33:18] d_value, rest zero.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [acd_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [acd_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [acd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  acd_pkg::acd_cfg_t     cfg;
  acd_pkg::acd_mul_req_t mul_req;
  acd_pkg::acd_mul_rsp_t mul_rsp;
  acd_pkg::acd_state_e   state_d, state_q;

  logic [acd_pkg::SAMPLE_BITS-1:0] x_d, x_q;
  logic [15:0]                     a_d, a_q;
  logic [acd_pkg::HALF_W-1:0]      half_d, half_q;
  logic signed [15:0]              d_d, d_q;
  logic signed [15:0]              z_d, z_q;
  logic [12:0]                     est_d, est_q;
  logic signed [15:0]              cusum_d, cusum_q;
  logic signed [15:0]              min_d, min_q;
  logic                            alarm_d, alarm_q;
  logic                            m_valid_d, m_valid_q;
  logic [acd_pkg::M_TDATA_W-1:0]   m_data_d, m_data_q;

  logic                            in_xfer, out_free;
  logic [15:0]                     b_val, sub_sel, op_mag, d_mag, prod16;
  logic [16:0]                     diff, diff_neg, est_sum;
  logic [acd_pkg::HALF_W-1:0]      half_new;
  logic [31:0]                     half_diff;
  logic signed [15:0]              sat_half;
  logic signed [16:0]              z_ext, dz_ext, z_low, csum, cusum_ext, limit, d_abs;
  logic                            in_band, alarm_hit, below_min, instant;

  // Configuration registers: always ready.
  assign cfg_ready_o = 1'b1;

  acd_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i & cfg_ready_o),
    .wr_addr_i (cfg_addr_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // Shared multiplier for all squares and the gain product.
  acd_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign s_axis_tready = (state_q == acd_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;

  // Distance of the sample from the level chosen for this pass.
  assign b_val = a_q + 16'(cfg.step_delta);

  always_comb begin
    unique case (state_q)
      acd_pkg::ST_LOAD_B: sub_sel = b_val;
      acd_pkg::ST_LOAD_M: sub_sel = 16'(cfg.ref_mean);
      acd_pkg::ST_LOAD_E: sub_sel = 16'(est_q);
      default:            sub_sel = a_q;
    endcase
  end

  assign diff     = 17'(x_q) - 17'(sub_sel);
  assign diff_neg = 17'd0 - diff;
  assign op_mag   = diff[16] ? diff_neg[15:0] : diff[15:0];

  // Half square of the latest product and the saturated difference of halves.
  assign half_new  = mul_rsp.product[2*acd_pkg::MUL_W-1:1];
  assign half_diff = {1'b0, half_q} - {1'b0, half_new};
  assign sat_half  = acd_pkg::sat16($signed(half_diff));

  // Magnitude of D for the gain product; the sign is applied afterwards.
  assign d_mag  = d_q[15] ? 16'(16'd0 - d_q) : d_q;
  assign prod16 = mul_rsp.product[15:0];

  // Changed-mean estimate, clamped without wrap.
  assign est_sum = 17'(a_q) + 17'(cfg.step_delta[7:1]);

  // Deadband test: -deadband < z < deadband.
  assign z_ext   = $signed({sat_half[15], sat_half});
  assign dz_ext  = $signed({2'b00, cfg.z_deadband});
  assign z_low   = z_ext + dz_ext;
  assign in_band = (z_low > 17'sd0) && (z_ext < dz_ext);

  // CUSUM accumulation with saturation.
  assign csum = $signed({cusum_q[15], cusum_q}) + $signed({z_q[15], z_q});

  // Alarm and minimum tracking against the updated CUSUM.
  assign cusum_ext = $signed({cusum_q[15], cusum_q});
  assign limit     = $signed({min_q[15], min_q}) + $signed({2'b00, cfg.alarm_threshold});
  assign alarm_hit = cusum_ext >= limit;
  assign below_min = cusum_q < min_q;

  // Instant-change flag from |D|.
  assign d_abs   = d_q[15] ? (17'sd0 - $signed({d_q[15], d_q})) : $signed({d_q[15], d_q});
  assign instant = d_abs > $signed({2'b00, cfg.d_bound});

  // Sequencer: next state, multiplier requests and datapath updates.
  always_comb begin
    state_d       = state_q;
    mul_req.start = 1'b0;
    mul_req.op_a  = op_mag;
    mul_req.op_b  = op_mag;
    x_d           = x_q;
    a_d           = a_q;
    half_d        = half_q;
    d_d           = d_q;
    z_d           = z_q;
    est_d         = est_q;
    cusum_d       = cusum_q;
    min_d         = min_q;
    alarm_d       = alarm_q;
    m_valid_d     = m_valid_q & ~m_axis_tready;
    m_data_d      = m_data_q;

    // A write to the mean or the gap restarts the lower estimate.
    if (cfg.reload) begin
      a_d = 16'(cfg.ref_mean) - 16'(cfg.step_delta[7:1]);
    end

    unique case (state_q)
      acd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          x_d     = s_axis_tdata[acd_pkg::SAMPLE_BITS-1:0];
          state_d = acd_pkg::ST_LOAD_A;
        end
      end
      acd_pkg::ST_LOAD_A: begin
        mul_req.start = 1'b1;
        state_d       = acd_pkg::ST_WAIT_A;
      end
      acd_pkg::ST_WAIT_A: begin
        if (mul_rsp.done) begin
          half_d  = half_new;
          state_d = acd_pkg::ST_LOAD_B;
        end
      end
      acd_pkg::ST_LOAD_B: begin
        mul_req.start = 1'b1;
        state_d       = acd_pkg::ST_WAIT_B;
      end
      acd_pkg::ST_WAIT_B: begin
        if (mul_rsp.done) begin
          d_d     = sat_half;
          state_d = acd_pkg::ST_LOAD_G;
        end
      end
      acd_pkg::ST_LOAD_G: begin
        mul_req.start = 1'b1;
        mul_req.op_a  = d_mag;
        mul_req.op_b  = 16'(cfg.adapt_gain);
        state_d       = acd_pkg::ST_WAIT_G;
      end
      acd_pkg::ST_WAIT_G: begin
        if (mul_rsp.done) begin
          a_d     = d_q[15] ? (a_q - prod16) : (a_q + prod16);
          state_d = acd_pkg::ST_LOAD_M;
        end
      end
      acd_pkg::ST_LOAD_M: begin
        mul_req.start = 1'b1;
        est_d = (est_sum > 17'(cfg.estimate_ceiling)) ? cfg.estimate_ceiling : est_sum[12:0];
        state_d       = acd_pkg::ST_WAIT_M;
      end
      acd_pkg::ST_WAIT_M: begin
        if (mul_rsp.done) begin
          half_d  = half_new;
          state_d = acd_pkg::ST_LOAD_E;
        end
      end
      acd_pkg::ST_LOAD_E: begin
        mul_req.start = 1'b1;
        state_d       = acd_pkg::ST_WAIT_E;
      end
      acd_pkg::ST_WAIT_E: begin
        if (mul_rsp.done) begin
          z_d     = in_band ? 16'sd0 : sat_half;
          state_d = acd_pkg::ST_UPDATE;
        end
      end
      acd_pkg::ST_UPDATE: begin
        if (csum[16] != csum[15]) begin
          cusum_d = csum[16] ? acd_pkg::SAT_MIN : acd_pkg::SAT_MAX;
        end else begin
          cusum_d = csum[15:0];
        end
        state_d = acd_pkg::ST_OUT;
      end
      acd_pkg::ST_OUT: begin
        if (out_free) begin
          if (alarm_hit) begin
            alarm_d = 1'b1;
          end else if (below_min) begin
            min_d = cusum_q;
          end
          m_valid_d = 1'b1;
          m_data_d  = acd_pkg::M_TDATA_W'({d_q, cusum_q, instant, alarm_q | alarm_hit});
          state_d   = acd_pkg::ST_IDLE;
        end
      end
      default: state_d = acd_pkg::ST_IDLE;
    endcase
  end

  // Control and detector state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= acd_pkg::ST_IDLE;
      a_q       <= 16'(acd_pkg::RST_REF_MEAN) - 16'(acd_pkg::RST_DELTA[7:1]);
      cusum_q   <= '0;
      min_q     <= '0;
      alarm_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      a_q       <= a_d;
      cusum_q   <= cusum_d;
      min_q     <= min_d;
      alarm_q   <= alarm_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    half_q   <= half_d;
    d_q      <= d_d;
    z_q      <= z_d;
    est_q    <= est_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The multiplier is free whenever a new sample can be taken.
  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !mul_rsp.busy)
    else $error("multiplier busy while the core is idle");

  // A multiplier result only ever arrives while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == acd_pkg::ST_WAIT_A || state_q == acd_pkg::ST_WAIT_B ||
                      state_q == acd_pkg::ST_WAIT_G || state_q == acd_pkg::ST_WAIT_M ||
                      state_q == acd_pkg::ST_WAIT_E))
    else $error("multiplier result outside a wait state");

  // The change alarm never clears once raised.
  a_alarm_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alarm_q |=> alarm_q)
    else $error("change alarm dropped");

  // Between samples the tracked minimum never exceeds the CUSUM.
  a_min_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == acd_pkg::ST_IDLE) |-> (min_q <= cusum_q))
    else $error("CUSUM minimum above the CUSUM");

endmodule

[verif/adaptive_cusum_change_detector_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive CUSUM change detector core: self-checking testbench
// A queue-fed driver streams samples into the core in bursts
// while the result side stalls on its own pattern. Every accepted sample is
// run through a behavioural model of the detector, and each result transfer
// is compared field by field with the oldest prediction. The run steps
// through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module adaptive_cusum_change_detector_core_tb;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int HOLD_CYCLES  = 700;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS  = 40;
  localparam int NUM_PHASES   = 12;
  localparam int HALF_PHASE   = 77;
  localparam int SAMPLE_MAX   = (1 << acd_pkg::SAMPLE_BITS) - 1;
  localparam int WRAP_MASK    = 'hFFFF;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [acd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    bit alarm;
    bit instant;
    int cusum;
    int d;
  } detector_result_t;

  typedef struct {
    logic [acd_pkg::CFG_IDX_W-1:0]  idx;
    logic [acd_pkg::CFG_DATA_W-1:0] val;
  } reg_write_t;

  // Clock, reset and block ports.
  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [acd_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [acd_pkg::M_TDATA_W-1:0]   m_axis_tdata;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [acd_pkg::CFG_IDX_W-1:0]   cfg_addr_i    = '0;
  logic [acd_pkg::CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // Stimulus and expectation stores.
  logic [acd_pkg::SAMPLE_BITS-1:0] sample_q[$];
  reg_write_t                      reg_write_q[$];
  detector_result_t                expected_q[$];

  // Detector model: register copies and state.
  int ref_mean_r  = acd_pkg::RST_REF_MEAN;
  int delta_r     = acd_pkg::RST_DELTA;
  int gain_r      = acd_pkg::RST_GAIN;
  int threshold_r = acd_pkg::RST_THRESHOLD;
  int ceiling_r   = acd_pkg::RST_CEILING;
  int deadband_r  = acd_pkg::RST_DEADBAND;
  int d_bound_r   = acd_pkg::RST_D_BOUND;
  int est_lower   = 0;  // reference mean less half delta, both zero at reset
  int cusum_r     = 0;
  int cusum_min_r = 0;
  bit alarm_r     = 1'b0;

  // Sender and receiver pacing.
  int burst_left  = 1;
  int gap_left    = 0;
  bit steady_send = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_ack    = 1'b0;
  int hold_left   = 0;
  int mode_left   = 0;
  int stall_mode  = 0;

  int mismatch_count = 0;
  int cycle_count    = 0;

  adaptive_cusum_change_detector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Free-running clock.
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  function automatic longint half_square(input longint v);
    return (v * v) / 2;
  endfunction

  function automatic int clamp16(input longint v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return int'(v);
  endfunction

  // Cut a random value to the width of the configuration data bus.
  function automatic logic [acd_pkg::CFG_DATA_W-1:0] cfg_word(input int unsigned v);
    return acd_pkg::CFG_DATA_W'(v);
  endfunction

  function automatic void reload_lower_estimate();
    est_lower = (ref_mean_r - (delta_r >> 1)) & WRAP_MASK;
  endfunction

  // One detector step: adapts the lower estimate, updates the CUSUM and
  // returns the result word that the sample should produce.
  function automatic detector_result_t detector_step(
    input logic [acd_pkg::SAMPLE_BITS-1:0] sample
  );
    int x;
    int upper;
    int est;
    int z;
    int dabs;
    detector_result_t r;
    x     = sample;
    upper = (est_lower + delta_r) & WRAP_MASK;
    r.d   = clamp16(half_square(x - est_lower) - half_square(x - upper));

    // Adaptation wraps at 16 bits; the changed-mean estimate does not.
    est_lower = (est_lower + gain_r * r.d) & WRAP_MASK;
    est       = est_lower + (delta_r >> 1);
    if (est > ceiling_r) begin
      est = ceiling_r;
    end

    z = clamp16(half_square(x - ref_mean_r) - half_square(x - est));
    if (z > -deadband_r && z < deadband_r) begin
      z = 0;
    end
    cusum_r = clamp16(longint'(cusum_r) + z);

    // The minimum is frozen on any step where the alarm condition holds.
    if (cusum_r >= cusum_min_r + threshold_r) begin
      alarm_r = 1'b1;
    end else if (cusum_r < cusum_min_r) begin
      cusum_min_r = cusum_r;
    end

    dabs      = (r.d < 0) ? -r.d : r.d;
    r.alarm   = alarm_r;
    r.instant = (dabs > d_bound_r);
    r.cusum   = cusum_r;
    return r;
  endfunction

  // Mostly samples close to the current level, with some spread and extremes.
  function automatic logic [acd_pkg::SAMPLE_BITS-1:0] pick_sample(input int level);
    int v;
    case ($urandom_range(0, 19))
      0: begin
        v = 0;
      end
      1: begin
        v = SAMPLE_MAX;
      end
      2, 3, 4: begin
        v = $urandom_range(0, SAMPLE_MAX);
      end
      default: begin
        v = level + int'($urandom_range(0, 64)) - 32;
      end
    endcase
    if (v < 0) begin
      v = 0;
    end else if (v > SAMPLE_MAX) begin
      v = SAMPLE_MAX;
    end
    return v[acd_pkg::SAMPLE_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    end
  endtask

  task automatic write_reg(input logic [acd_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [acd_pkg::CFG_DATA_W-1:0] val);
    reg_write_t w;
    w.idx = idx;
    w.val = val;
    reg_write_q.push_back(w);
  endtask

  task automatic settle_config();
    @(negedge clk_i);
    while (reg_write_q.size() != 0 || cfg_valid_i) begin
      @(negedge clk_i);
    end
  endtask

  task automatic push_samples(input int count, input int level);
    for (int i = 0; i < count; i++) begin
      sample_q.push_back(pick_sample(level));
    end
  endtask

  // Returns once every queued sample has been taken and every result seen.
  task automatic wait_results_drained();
    @(negedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // Sample driver: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin : sample_driver
    logic [acd_pkg::S_TDATA_W-1:0] word;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(detector_step(s_axis_tdata[acd_pkg::SAMPLE_BITS-1:0]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 && !steady_send) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          word                           = '0;
          word[acd_pkg::SAMPLE_BITS-1:0] = sample_q.pop_front();
          s_axis_tvalid                 <= 1'b1;
          s_axis_tdata                  <= word;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Register write driver; the model takes each write at its transfer.
  always @(posedge clk_i) begin : reg_driver
    reg_write_t w;
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          acd_pkg::REG_REFERENCE_MEAN: begin
            ref_mean_r = cfg_data_i[11:0];
            reload_lower_estimate();
          end
          acd_pkg::REG_STEP_DELTA: begin
            delta_r = cfg_data_i[7:0];
            reload_lower_estimate();
          end
          acd_pkg::REG_ADAPT_GAIN:       gain_r      = cfg_data_i[7:0];
          acd_pkg::REG_ALARM_THRESHOLD:  threshold_r = cfg_data_i[14:0];
          acd_pkg::REG_ESTIMATE_CEILING: ceiling_r   = cfg_data_i[12:0];
          acd_pkg::REG_Z_DEADBAND:       deadband_r  = cfg_data_i[14:0];
          acd_pkg::REG_D_BOUND:          d_bound_r   = cfg_data_i[14:0];
          default: begin
          end
        endcase
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (reg_write_q.size() != 0) begin
          w            = reg_write_q.pop_front();
          cfg_valid_i <= 1'b1;
          cfg_addr_i  <= w.idx;
          cfg_data_i  <= w.val;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result receiver: a long hold-off on request, otherwise a mix of stall
  // patterns, each picked at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack      <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 31) == 0);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin : check_result
      detector_result_t want;
      int got_cusum;
      int got_d;
      got_cusum = $signed(m_axis_tdata[17:2]);
      got_d     = $signed(m_axis_tdata[33:18]);
      if (expected_q.size() == 0) begin
        report_mismatch("result transfer with no sample pending", got_cusum, 0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[0] != want.alarm) begin
          report_mismatch("change_alarm", m_axis_tdata[0], want.alarm);
        end
        if (m_axis_tdata[1] != want.instant) begin
          report_mismatch("instant_change", m_axis_tdata[1], want.instant);
        end
        if (got_cusum != want.cusum) begin
          report_mismatch("cusum_value", got_cusum, want.cusum);
        end
        if (got_d != want.d) begin
          report_mismatch("d_value", got_d, want.d);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    int level;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed samples at the reset settings: range ends and bit patterns.
    sample_q = '{12'h000, 12'h001, 12'h002, 12'hFFF, 12'hFFF, 12'h800,
                 12'hAAA, 12'h555, 12'h7FF, 12'hFFE, 12'h000, 12'h000};
    wait_results_drained();

    // A write to an unmapped index must leave every setting as it was.
    write_reg(REG_UNMAPPED, 15'h7FFF);
    settle_config();
    sample_q = '{12'h000, 12'hFFF, 12'h123};
    wait_results_drained();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0) begin
        // Upper extremes, written with every data bit set, and no deadband.
        write_reg(acd_pkg::REG_REFERENCE_MEAN, 15'h7FFF);
        write_reg(acd_pkg::REG_STEP_DELTA, 15'h7FFF);
        write_reg(acd_pkg::REG_ADAPT_GAIN, 15'h7FFF);
        write_reg(acd_pkg::REG_ALARM_THRESHOLD, 15'h7FFF);
        write_reg(acd_pkg::REG_ESTIMATE_CEILING, 15'h7FFF);
        write_reg(acd_pkg::REG_Z_DEADBAND, 15'h0000);
        write_reg(acd_pkg::REG_D_BOUND, 15'h0000);
      end else if (phase == 1) begin
        // Lower extremes: no gap, no adaptation, estimate clamped to zero; deadband and D bound at their maximum.
        write_reg(acd_pkg::REG_REFERENCE_MEAN, 15'h0000);
        write_reg(acd_pkg::REG_STEP_DELTA, 15'h0000);
        write_reg(acd_pkg::REG_ADAPT_GAIN, 15'h0000);
        write_reg(acd_pkg::REG_ESTIMATE_CEILING, 15'h0000);
        write_reg(acd_pkg::REG_Z_DEADBAND, 15'h7FFF);
        write_reg(acd_pkg::REG_D_BOUND, 15'h7FFF);
      end else begin
        // Random settings; the last phases allow an immediate alarm.
        if ($urandom_range(0, 1)) begin
          write_reg(acd_pkg::REG_REFERENCE_MEAN, cfg_word($urandom));
        end
        if ($urandom_range(0, 1)) begin
          write_reg(acd_pkg::REG_STEP_DELTA, cfg_word($urandom));
        end
        if ($urandom_range(0, 1)) begin
          write_reg(acd_pkg::REG_ADAPT_GAIN, cfg_word($urandom_range(0, 15)));
        end
        if (phase >= NUM_PHASES - 2) begin
          write_reg(acd_pkg::REG_ALARM_THRESHOLD, 15'h0000);
        end else if ($urandom_range(0, 1)) begin
          write_reg(acd_pkg::REG_ALARM_THRESHOLD, cfg_word($urandom));
        end
        if ($urandom_range(0, 1)) begin
          write_reg(acd_pkg::REG_ESTIMATE_CEILING, cfg_word($urandom));
        end
        if ($urandom_range(0, 1)) begin
          write_reg(acd_pkg::REG_Z_DEADBAND, cfg_word($urandom_range(0, 400)));
        end
        if ($urandom_range(0, 1)) begin
          write_reg(acd_pkg::REG_D_BOUND, cfg_word($urandom_range(0, 2000)));
        end
      end
      settle_config();

      // In one phase the receiver holds off while the sender keeps offering.
      if (phase == 3) begin
        steady_send = 1'b1;
        hold_req    = ~hold_req;
      end

      // Samples around the reference mean, a full pause, then a shifted level.
      push_samples(HALF_PHASE, ref_mean_r);
      wait_results_drained();
      steady_send = 1'b0;
      level = ref_mean_r + int'($urandom_range(0, 2400)) - 1200;
      push_samples(HALF_PHASE, level);
      wait_results_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
